>>> hdl/hufd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hufd_pkg
// Shared types and constants of the Huffman tree-walk decoder.
// ============================================================================
package hufd_pkg;

    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int CNT_W  = 4;
    localparam int BYTE_W = 8;

    typedef logic [IDX_W-1:0] node_idx_t;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CODE = 1'b1;

    // One node table entry, 27 bits.
    typedef struct packed {
        logic             leaf;
        node_idx_t        left;
        node_idx_t        right;
        logic [SYM_W-1:0] symbol;
    } node_entry_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROOT  = 6'b000010,
        S_CUR   = 6'b000100,
        S_BIT   = 6'b001000,
        S_NEXT  = 6'b010000,
        S_FLUSH = 6'b100000
    } walk_state_t;

    // Child taken from a node for one code bit: zero goes left, one goes right.
    function automatic node_idx_t child_sel(input node_entry_t e, input logic b);
        child_sel = b ? e.right : e.left;
    endfunction

endpackage

>>> hdl/huffman_tree_walk_decoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// huffman_tree_walk_decoder_core
// Huffman decoder that walks a code tree stored in a node table memory.
// ============================================================================
//
// Usage:
//   The slave channel (s_*) carries two kinds of transfer, told apart by
//   s_tuser. A load transfer writes one node table entry.
//   A code transfer brings one byte and a count of valid leading bits; each
//   bit steps the walk to a child, and every leaf reached sends one symbol on
//   the master channel (m_*). m_tlast marks the last symbol of a code byte.
//   The decoder accepts a new transfer only when the previous byte is fully
//   decoded, so s_tready is high in the idle state only.
//   While a code byte is decoded, s_tready stays low. When the root is an
//   inner node the walk does one node table read per bit, back to back on
//   the single read port unless the output stalls; the cached root and
//   current node entries are refetched first after a load transfer or a
//   root write.
//   cfg_we writes root_index and moves the walk to the new root.
//   Reset clears the root to zero and the walk to the root; the node table
//   is not cleared and must be loaded before use.
//   When the receiver stalls, one symbol waits in the output register and a
//   second in a hold register; the walk then pauses until space frees up.
//
module huffman_tree_walk_decoder_core
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = 512
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: entry_index[8:0], entry_is_leaf[9], entry_left[18:10],
    // entry_right[27:19], entry_symbol[35:28], code_byte[43:36], valid_bits[47:44]
    input  logic [47:0] s_tdata,
    // s_tuser: req_type (0 load, 1 code)
    input  logic        s_tuser,

    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: symbol[7:0]
    output logic [7:0]  m_tdata,
    // m_tlast: last_of_byte
    output logic        m_tlast,

    // Root index register.
    input  logic        cfg_we,
    input  node_idx_t   cfg_wdata
);

    // Input fields.
    logic              req_type;
    node_idx_t         entry_index;
    node_entry_t       entry_in;
    logic [BYTE_W-1:0] code_byte;
    logic [CNT_W-1:0]  valid_bits;
    logic [CNT_W-1:0]  bit_count;

    assign req_type       = s_tuser;
    assign entry_index    = s_tdata[8:0];
    assign entry_in.leaf  = s_tdata[9];
    assign entry_in.left  = s_tdata[18:10];
    assign entry_in.right = s_tdata[27:19];
    assign entry_in.symbol = s_tdata[35:28];
    assign code_byte      = s_tdata[43:36];
    assign valid_bits     = s_tdata[47:44];

    // Counts above one byte are treated as a full byte.
    assign bit_count = (valid_bits > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W) : valid_bits;

    // Registers.
    walk_state_t       state_reg,     state_next;
    node_idx_t         root_reg,      root_next;
    node_idx_t         walk_reg,      walk_next;
    node_idx_t         next_idx_reg,  next_idx_next;
    node_entry_t       root_e_reg,    root_e_next;
    node_entry_t       cur_e_reg,     cur_e_next;
    logic              cache_ok_reg,  cache_ok_next;
    logic [BYTE_W-1:0] byte_reg,      byte_next;
    logic [CNT_W-1:0]  bits_left_reg, bits_left_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]  hold_sym_reg,  hold_sym_next;
    logic              out_valid_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic              out_last_reg;

    // Memory port.
    logic        rd_en;
    node_idx_t   rd_addr;
    node_entry_t rd_data;
    logic        wr_en;

    // Control.
    logic        in_fire;
    logic        out_free;
    logic        emit_ok;
    logic        last_bit;
    logic        push;
    logic        push_last;
    logic [SYM_W-1:0] push_sym;
    node_entry_t new_cur;

    hufd_node_ram #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_index),
        .wr_data (entry_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // The output register can take a symbol if it is empty or drains now.
    assign out_free = !out_valid_reg || m_tready;
    // A new symbol goes to the hold register; a symbol already held must move
    // to the output register first, since it is now known not to be the last.
    assign emit_ok  = !hold_valid_reg || out_free;
    assign last_bit = (bits_left_reg == CNT_W'(1));

    // After a child read, the walk continues from that child, or from the
    // root once a leaf was reached.
    assign new_cur = rd_data.leaf ? root_e_reg : rd_data;

    always_comb
    begin
        state_next      = state_reg;
        root_next       = root_reg;
        walk_next       = walk_reg;
        next_idx_next   = next_idx_reg;
        root_e_next     = root_e_reg;
        cur_e_next      = cur_e_reg;
        cache_ok_next   = cache_ok_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        rd_en           = 1'b0;
        rd_addr         = root_reg;
        wr_en           = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;
        push_sym        = hold_sym_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        // Any entry may change, so the cached entries are stale.
                        wr_en         = 1'b1;
                        cache_ok_next = 1'b0;
                    end
                    else if (bit_count != '0)
                    begin
                        byte_next      = code_byte;
                        bits_left_next = bit_count;
                        if (cache_ok_reg)
                        begin
                            state_next = S_BIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = root_reg;
                            state_next = S_ROOT;
                        end
                    end
                end
            end

            S_ROOT:
            begin
                root_e_next = rd_data;
                rd_en       = 1'b1;
                rd_addr     = walk_reg;
                state_next  = S_CUR;
            end

            S_CUR:
            begin
                cur_e_next    = rd_data;
                cache_ok_next = 1'b1;
                state_next    = S_BIT;
            end

            S_BIT:
            begin
                if (root_e_reg.leaf)
                begin
                    // Leaf root: every bit yields the root symbol.
                    if (emit_ok)
                    begin
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = root_e_reg.symbol;
                        walk_next       = root_reg;
                        cur_e_next      = root_e_reg;
                        byte_next       = byte_reg << 1;
                        bits_left_next  = bits_left_reg - CNT_W'(1);
                        state_next      = last_bit ? S_FLUSH : S_BIT;
                    end
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = child_sel(cur_e_reg, byte_reg[BYTE_W-1]);
                    next_idx_next = rd_addr;
                    state_next    = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (!rd_data.leaf || emit_ok)
                begin
                    if (rd_data.leaf)
                    begin
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = rd_data.symbol;
                        walk_next       = root_reg;
                    end
                    else
                    begin
                        walk_next = next_idx_reg;
                    end
                    cur_e_next     = new_cur;
                    byte_next      = byte_reg << 1;
                    bits_left_next = bits_left_reg - CNT_W'(1);
                    if (last_bit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        // Issue the read for the following bit right away.
                        rd_en         = 1'b1;
                        rd_addr       = child_sel(new_cur, byte_reg[BYTE_W-2]);
                        next_idx_next = rd_addr;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // User writes root only while idle, unchecked; walk restarts at new root.
        if (cfg_we)
        begin
            root_next     = cfg_wdata;
            walk_next     = cfg_wdata;
            cache_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_reg       <= '0;
            walk_reg       <= '0;
            cache_ok_reg   <= 1'b0;
            bits_left_reg  <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            walk_reg       <= walk_next;
            cache_ok_reg   <= cache_ok_next;
            bits_left_reg  <= bits_left_next;
            hold_valid_reg <= hold_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        next_idx_reg <= next_idx_next;
        root_e_reg   <= root_e_next;
        cur_e_reg    <= cur_e_next;
        byte_reg     <= byte_next;
        hold_sym_reg <= hold_sym_next;
        if (push)
        begin
            out_sym_reg  <= push_sym;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;

    // A held symbol is always flushed before the decoder returns to idle.
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held symbol left behind in idle");

    // While walking, at least one bit of the byte remains.
    a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BIT) || (state_reg == S_NEXT)) |-> (bits_left_reg != '0))
        else $error("walk state with no bits left");

    // A load transfer invalidates the cached root and current entries.
    a_load_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == REQ_LOAD)) |=> !cache_ok_reg)
        else $error("cache still valid after a table load");

    // A root write restarts the walk at the new root.
    a_root_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (walk_reg == root_reg))
        else $error("walk position not moved to the new root");

endmodule

>>> hdl/hufd_node_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// hufd_node_ram
// Node table: one write port, one read port with a registered read result.
// ============================================================================
module hufd_node_ram
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = 512
)
(
    input  logic        clk,
    input  logic        wr_en,
    input  node_idx_t   wr_addr,
    input  node_entry_t wr_data,
    input  logic        rd_en,
    input  node_idx_t   rd_addr,
    output node_entry_t rd_data
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    node_entry_t mem [NODE_COUNT];
    node_entry_t rd_data_reg;

    logic wr_in_range;
    logic rd_in_range;

    // Indices at or beyond the table size are dropped on write and read as zero.
    assign wr_in_range = ({1'b0, wr_addr} < (IDX_W + 1)'(NODE_COUNT));
    assign rd_in_range = ({1'b0, rd_addr} < (IDX_W + 1)'(NODE_COUNT));

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rd_in_range ? mem[rd_addr[ADDR_W-1:0]] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
